// ===== rtl/rmq_pkg.sv =====
// Shared types, codes and width helpers for the rotation matrix to quaternion unit.
`default_nettype none

package rmq_pkg;

  localparam int unsigned FracBitsDefault = 14;

  localparam logic [1:0] BranchTrace = 2'd0;
  localparam logic [1:0] BranchZ     = 2'd1;
  localparam logic [1:0] BranchX     = 2'd2;
  localparam logic [1:0] BranchY     = 2'd3;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadAxis = 2'd1,
    StatusZeroLen = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [15:0] m_xx;
    logic signed [15:0] m_xy;
    logic signed [15:0] m_xz;
    logic signed [15:0] m_yx;
    logic signed [15:0] m_yy;
    logic signed [15:0] m_yz;
    logic signed [15:0] m_zx;
    logic signed [15:0] m_zy;
    logic signed [15:0] m_zz;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [15:0] q_w;
    logic [1:0]         branch_used;
    logic [1:0]         status;
  } rmq_out_t;

  // Side information that travels with the chosen candidate.
  typedef struct packed {
    logic [1:0] branch;
    logic [1:0] status;
    logic [3:0] neg;
  } rmq_tag_t;

  // Width of a candidate component magnitude for a given fraction width.
  function automatic int unsigned mag_width(input int unsigned frac);
    return (frac >= 17) ? frac + 1 : 18;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// Top level of the rotation matrix to unit quaternion converter.
`default_nettype none

// Takes one 3x3 rotation matrix per beat and returns the unit quaternion, the chosen
// candidate and a status. A new matrix is accepted every cycle while the two-entry output
// buffer has room. Four register stages form and select the candidate, M + 1 stages
// compute the square root one bit each, where M is max(FracBits + 1, 18), FracBits + 2
// stages divide the components one quotient bit each, and the output buffer registers
// the result. Stalls from the consumer hold the whole pipeline; nothing is lost or repeated.
module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned FracBits = rmq_pkg::FracBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rmq_pkg::rmq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rmq_pkg::rmq_out_t out_data_o
);
  import rmq_pkg::*;

  localparam int unsigned MagW  = mag_width(FracBits);
  localparam int unsigned RootW = MagW + 1;
  localparam int unsigned LenW  = 2 * RootW;
  localparam int unsigned QuoW  = FracBits + 1;
  localparam int unsigned SatW  = (QuoW + 1 > 17) ? QuoW + 1 : 17;
  localparam logic [QuoW-1:0]        OneQ   = QuoW'(1) << FracBits;
  localparam logic signed [SatW-1:0] PosLim = SatW'(32767);
  localparam logic signed [SatW-1:0] NegLim = -(SatW'(32768));

  logic                 en;
  logic                 front_v, sqrt_v, div_v;
  logic [3:0][MagW-1:0] front_mag, sqrt_mag;
  logic [LenW-1:0]      front_len;
  logic [RootW-1:0]     sqrt_root;
  logic [3:0][QuoW-1:0] div_quo;
  rmq_tag_t             front_tag, sqrt_tag, div_tag;
  logic                 buf_full;
  logic [3:0][15:0]     q_fmt;
  rmq_out_t             res;

  // The pipeline only halts when a finished beat has nowhere to go.
  assign en         = !div_v || !buf_full;
  assign in_ready_o = en;

  rmq_front #(.FracBits(FracBits)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (front_v),
    .mag_o   (front_mag),
    .len_o   (front_len),
    .tag_o   (front_tag)
  );

  rmq_isqrt #(.FracBits(FracBits)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .len_i   (front_len),
    .mag_i   (front_mag),
    .tag_i   (front_tag),
    .valid_o (sqrt_v),
    .root_o  (sqrt_root),
    .mag_o   (sqrt_mag),
    .tag_o   (sqrt_tag)
  );

  rmq_div #(.FracBits(FracBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_v),
    .root_i  (sqrt_root),
    .mag_i   (sqrt_mag),
    .tag_i   (sqrt_tag),
    .valid_o (div_v),
    .quo_o   (div_quo),
    .tag_o   (div_tag)
  );

  // Restore signs and saturate to one and then to the 16-bit range.
  always_comb begin
    logic [QuoW-1:0]        qm;
    logic signed [SatW-1:0] sv;
    for (int j = 0; j < 4; j++) begin
      qm = (div_quo[j] > OneQ) ? OneQ : div_quo[j];
      sv = div_tag.neg[j] ? -(SatW'(qm)) : SatW'(qm);
      if (sv > PosLim) begin
        sv = PosLim;
      end else if (sv < NegLim) begin
        sv = NegLim;
      end
      q_fmt[j] = sv[15:0];
    end
  end

  always_comb begin
    res.q_x         = q_fmt[0];
    res.q_y         = q_fmt[1];
    res.q_z         = q_fmt[2];
    res.q_w         = q_fmt[3];
    res.branch_used = div_tag.branch;
    res.status      = div_tag.status;
  end

  rmq_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en & div_v),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rmq_front.sv =====
// Candidate forming, squared lengths and candidate selection, four register stages.
`default_nettype none

module rmq_front #(
  parameter int unsigned FracBits = rmq_pkg::FracBitsDefault,
  localparam int unsigned MagW = rmq_pkg::mag_width(FracBits),
  localparam int unsigned LenW = 2 * MagW + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  rmq_pkg::rmq_in_t      data_i,
  output logic                  valid_o,
  output logic [3:0][MagW-1:0]  mag_o,
  output logic [LenW-1:0]       len_o,
  output rmq_pkg::rmq_tag_t     tag_o
);
  import rmq_pkg::*;

  localparam int unsigned CandW = MagW + 1;
  localparam int unsigned SqW   = 2 * MagW;
  localparam logic signed [CandW-1:0] OneC = CandW'(64'd1 << FracBits);
  localparam logic [LenW-1:0] OneSq = LenW'(1) << (2 * FracBits);

  function automatic logic signed [CandW-1:0] sx(input logic [15:0] v);
    return {{(CandW-16){v[15]}}, v};
  endfunction

  logic signed [CandW-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz;
  logic signed [CandW-1:0] cand_d [4][4];
  logic signed [CandW-1:0] cand1_q [4][4];
  logic v1_q, v2_q, v3_q, v4_q;

  logic [3:0][3:0][MagW-1:0] mag_d, mag2_q, mag3_q;
  logic [3:0][3:0][SqW-1:0]  sq_d, sq2_q;
  logic [3:0][3:0]           neg_d, neg2_q, neg3_q;
  logic [3:0][LenW-1:0]      len_d, len3_q;

  logic [3:0]           qual;
  logic [1:0]           branch_sel;
  status_e              status_sel;
  logic [LenW-1:0]      len_sel;
  logic [3:0][MagW-1:0] mag4_q;
  logic [LenW-1:0]      len4_q;
  rmq_tag_t             tag4_q;

  assign xx = sx(data_i.m_xx);
  assign xy = sx(data_i.m_xy);
  assign xz = sx(data_i.m_xz);
  assign yx = sx(data_i.m_yx);
  assign yy = sx(data_i.m_yy);
  assign yz = sx(data_i.m_yz);
  assign zx = sx(data_i.m_zx);
  assign zy = sx(data_i.m_zy);
  assign zz = sx(data_i.m_zz);

  // Components are ordered x, y, z, w; candidates trace, z, x, y.
  always_comb begin
    cand_d[0][0] = yz - zy;
    cand_d[0][1] = zx - xz;
    cand_d[0][2] = xy - yx;
    cand_d[0][3] = OneC + xx + yy + zz;
    cand_d[1][0] = xz + zx;
    cand_d[1][1] = zy + yz;
    cand_d[1][2] = OneC + zz - yy - xx;
    cand_d[1][3] = xy - yx;
    cand_d[2][0] = OneC + xx - yy - zz;
    cand_d[2][1] = yx + xy;
    cand_d[2][2] = xz + zx;
    cand_d[2][3] = yz - zy;
    cand_d[3][0] = yx + xy;
    cand_d[3][1] = OneC + yy - xx - zz;
    cand_d[3][2] = zy + yz;
    cand_d[3][3] = zx - xz;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        neg_d[k][j] = cand1_q[k][j][CandW-1];
        mag_d[k][j] = neg_d[k][j] ? MagW'(-cand1_q[k][j]) : MagW'(cand1_q[k][j]);
        sq_d[k][j]  = mag_d[k][j] * mag_d[k][j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      len_d[k] = (LenW'(sq2_q[k][0]) + LenW'(sq2_q[k][1]))
               + (LenW'(sq2_q[k][2]) + LenW'(sq2_q[k][3]));
    end
  end

  // The first candidate reaching unit squared length wins; otherwise the y candidate.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qual[k] = |len3_q[k][LenW-1:2*FracBits];
    end
    branch_sel = BranchY;
    status_sel = StatusBadAxis;
    if (qual[0]) begin
      branch_sel = BranchTrace;
      status_sel = StatusOk;
    end else if (qual[1]) begin
      branch_sel = BranchZ;
      status_sel = StatusOk;
    end else if (qual[2]) begin
      branch_sel = BranchX;
      status_sel = StatusOk;
    end else if (qual[3]) begin
      branch_sel = BranchY;
      status_sel = StatusOk;
    end
    len_sel = len3_q[branch_sel];
    if (len_sel == '0) begin
      len_sel    = OneSq;
      status_sel = StatusZeroLen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cand1_q       <= cand_d;
      mag2_q        <= mag_d;
      sq2_q         <= sq_d;
      neg2_q        <= neg_d;
      mag3_q        <= mag2_q;
      neg3_q        <= neg2_q;
      len3_q        <= len_d;
      mag4_q        <= mag3_q[branch_sel];
      len4_q        <= len_sel;
      tag4_q.branch <= branch_sel;
      tag4_q.status <= status_sel;
      tag4_q.neg    <= neg3_q[branch_sel];
    end
  end

  assign valid_o = v4_q;
  assign mag_o   = mag4_q;
  assign len_o   = len4_q;
  assign tag_o   = tag4_q;

endmodule

`default_nettype wire

// ===== rtl/rmq_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
`default_nettype none

module rmq_isqrt #(
  parameter int unsigned FracBits = rmq_pkg::FracBitsDefault,
  localparam int unsigned MagW  = rmq_pkg::mag_width(FracBits),
  localparam int unsigned RootW = MagW + 1,
  localparam int unsigned LenW  = 2 * RootW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [LenW-1:0]       len_i,
  input  logic [3:0][MagW-1:0]  mag_i,
  input  rmq_pkg::rmq_tag_t     tag_i,
  output logic                  valid_o,
  output logic [RootW-1:0]      root_o,
  output logic [3:0][MagW-1:0]  mag_o,
  output rmq_pkg::rmq_tag_t     tag_o
);
  import rmq_pkg::*;

  localparam int unsigned RemW = RootW + 2;

  logic                 v_s    [RootW+1];
  logic [RootW-1:0]     root_s [RootW+1];
  logic [3:0][MagW-1:0] mag_s  [RootW+1];
  rmq_tag_t             tag_s  [RootW+1];
  logic [RemW-1:0]      rem_s  [RootW];
  logic [LenW-1:0]      rad_s  [RootW];

  assign v_s[0]    = valid_i;
  assign root_s[0] = '0;
  assign mag_s[0]  = mag_i;
  assign tag_s[0]  = tag_i;
  assign rem_s[0]  = '0;
  assign rad_s[0]  = len_i;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic            ge;

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_s[k][RemW-3:0], rad_s[k][LenW-1 -: 2]};
    assign trial  = {root_s[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_s[k+1] <= {root_s[k][RootW-2:0], ge};
        mag_s[k+1]  <= mag_s[k];
        tag_s[k+1]  <= tag_s[k];
      end
    end

    if (k + 1 < RootW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_s[k+1] <= ge ? rem_sh - trial : rem_sh;
          rad_s[k+1] <= rad_s[k] << 2;
        end
      end
    end
  end

  assign valid_o = v_s[RootW];
  assign root_o  = root_s[RootW];
  assign mag_o   = mag_s[RootW];
  assign tag_o   = tag_s[RootW];

endmodule

`default_nettype wire

// ===== rtl/rmq_div.sv =====
// Pipelined rounding divider for the four components, one quotient bit per stage.
`default_nettype none

module rmq_div #(
  parameter int unsigned FracBits = rmq_pkg::FracBitsDefault,
  localparam int unsigned MagW  = rmq_pkg::mag_width(FracBits),
  localparam int unsigned RootW = MagW + 1,
  localparam int unsigned QuoW  = FracBits + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [RootW-1:0]      root_i,
  input  logic [3:0][MagW-1:0]  mag_i,
  input  rmq_pkg::rmq_tag_t     tag_i,
  output logic                  valid_o,
  output logic [3:0][QuoW-1:0]  quo_o,
  output rmq_pkg::rmq_tag_t     tag_o
);
  import rmq_pkg::*;

  localparam int unsigned NumW = MagW + FracBits + 1;

  logic [3:0][NumW-1:0]  num;
  logic                  v_s    [QuoW+1];
  rmq_tag_t              tag_s  [QuoW+1];
  logic [3:0][QuoW-1:0]  quo_s  [QuoW+1];
  logic [RootW-1:0]      root_s [QuoW];
  logic [3:0][RootW-1:0] rem_s  [QuoW];
  logic [3:0][QuoW-1:0]  low_s  [QuoW];

  // Numerator is |c| * ONE plus half the divisor, so the quotient rounds half up.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      num[j] = NumW'({mag_i[j], {FracBits{1'b0}}}) + NumW'(root_i[RootW-1:1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s[0] <= 1'b0;
    end else if (en_i) begin
      v_s[0] <= valid_i;
    end
  end

  // The upper numerator bits are already below the divisor, as the quotient fits QuoW bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_s[0]  <= tag_i;
      root_s[0] <= root_i;
      for (int j = 0; j < 4; j++) begin
        rem_s[0][j] <= RootW'(num[j][NumW-1:QuoW]);
        low_s[0][j] <= num[j][QuoW-1:0];
      end
    end
  end

  assign quo_s[0] = '0;

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [3:0][RootW:0]   rem_sh;
    logic [3:0][RootW:0]   diff;
    logic [3:0]            ge;
    logic [3:0][RootW-1:0] rem_nx;

    always_comb begin
      for (int j = 0; j < 4; j++) begin
        rem_sh[j] = {rem_s[k][j], low_s[k][j][QuoW-1]};
        diff[j]   = rem_sh[j] - {1'b0, root_s[k]};
        ge[j]     = rem_sh[j] >= {1'b0, root_s[k]};
        rem_nx[j] = ge[j] ? diff[j][RootW-1:0] : rem_sh[j][RootW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_s[k+1] <= tag_s[k];
        for (int j = 0; j < 4; j++) begin
          quo_s[k+1][j] <= {quo_s[k][j][QuoW-2:0], ge[j]};
        end
      end
    end

    if (k + 1 < QuoW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          root_s[k+1] <= root_s[k];
          for (int j = 0; j < 4; j++) begin
            rem_s[k+1][j] <= rem_nx[j];
            low_s[k+1][j] <= low_s[k][j] << 1;
          end
        end
      end
    end
  end

  assign valid_o = v_s[QuoW];
  assign quo_o   = quo_s[QuoW];
  assign tag_o   = tag_s[QuoW];

endmodule

`default_nettype wire

// ===== rtl/rmq_outbuf.sv =====
// Two-entry output buffer that decouples the pipeline from the result consumer.
`default_nettype none

module rmq_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rmq_pkg::rmq_out_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output rmq_pkg::rmq_out_t data_o
);
  import rmq_pkg::*;

  rmq_out_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop   = valid_o & ready_i;
  assign cnt_d = cnt_q + 2'(push_i) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/rmq_checker.sv =====
// Port-level checks for the rotation matrix to quaternion unit, with its bind.
`default_nettype none

module rmq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input rmq_pkg::rmq_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input rmq_pkg::rmq_out_t out_data_o
);
  import rmq_pkg::*;

  // With no result waiting, nothing can hold the pipeline back.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while output buffer is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed or vanished");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input beat changed or vanished");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusZeroLen |->
      out_data_o.q_x == '0 && out_data_o.q_y == '0 &&
      out_data_o.q_z == '0 && out_data_o.q_w == '0)
    else $error("zero length result has a nonzero component");

  a_bad_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusBadAxis |->
      out_data_o.branch_used == BranchY)
    else $error("bad axis result not taken from the y candidate");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_checker (.*);

`default_nettype wire
